// File: rtl/mss_pkg.sv
// ============================================================================
// mss_pkg
// Shared types, opcodes and result codes for the MIPS subset step engine.
// ============================================================================
package mss_pkg;

    // Default depth of the unified instruction/data memory, in words
    localparam int MEM_WORDS_DEF = 1024;

    // Width of a word index taken from a 32-bit byte address
    localparam int WORD_IDX_W = 30;

    // Primary opcodes, bits 31:26
    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2B;
    localparam logic [5:0] OP_BEQ   = 6'h04;

    // R-type function codes, bits 5:0
    localparam logic [5:0] FN_ADD = 6'h20;
    localparam logic [5:0] FN_SUB = 6'h22;

    typedef enum logic [3:0] {
        K_LOAD     = 4'd0,
        K_ADD      = 4'd1,
        K_SUB      = 4'd2,
        K_RNOP     = 4'd3,
        K_ADDI     = 4'd4,
        K_LW       = 4'd5,
        K_SW       = 4'd6,
        K_BEQ_T    = 4'd7,
        K_BEQ_N    = 4'd8,
        K_UNKNOWN  = 4'd9,
        K_HALT     = 4'd10
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_MAP,
        S_ACCESS,
        S_LOAD_WB
    } state_t;

    typedef struct packed {
        logic        req_type;
        logic [9:0]  load_addr;
        logic [31:0] load_data;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] exec_pc;
        logic [31:0] instr_word;
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_written;
        logic [31:0] mem_byte_addr;
        logic [31:0] mem_value;
        logic [31:0] next_pc;
    } out_item_t;

    // Register file write port
    typedef struct packed {
        logic        en;
        logic [4:0]  idx;
        logic [31:0] data;
    } rf_wr_t;

    // Decoded and executed instruction, held across the memory phases
    typedef struct packed {
        kind_t       kind;
        logic        is_mem;
        rf_wr_t      wr;
        logic [31:0] ea;
        logic [31:0] store_data;
        logic [31:0] npc;
    } exec_t;

endpackage

// File: rtl/mss_umem.sv
// ============================================================================
// mss_umem
// Unified instruction/data memory: one write port, one registered read port.
// ============================================================================
module mss_umem #(
    parameter int MEM_WORDS = mss_pkg::MEM_WORDS_DEF
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [$clog2(MEM_WORDS)-1:0] waddr,
    input  logic [31:0]                  wdata,
    input  logic                         re,
    input  logic [$clog2(MEM_WORDS)-1:0] raddr,
    output logic [31:0]                  rdata
);
    import mss_pkg::*;

    logic [31:0] mem [MEM_WORDS];
    logic [31:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/mss_regfile.sv
// ============================================================================
// mss_regfile
// 32 x 32 register file, two registered read ports, one write port.
// Per-entry valid bits make unwritten entries (and R0) read as zero.
// ============================================================================
module mss_regfile (
    input  logic            aclk,
    input  logic            aresetn,
    input  mss_pkg::rf_wr_t wr,
    input  logic            re,
    input  logic [4:0]      raddr_a,
    input  logic [4:0]      raddr_b,
    output logic [31:0]     rdata_a,
    output logic [31:0]     rdata_b
);
    import mss_pkg::*;

    logic [31:0] regs [32];
    logic [31:0] valid_reg;
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;
    logic        wr_ok;

    // never write R0
    assign wr_ok = wr.en && (wr.idx != 5'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_ok) begin
            valid_reg[wr.idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            regs[wr.idx] <= wr.data;
        end
        if (re) begin
            rd_a_reg <= valid_reg[raddr_a] ? regs[raddr_a] : 32'd0;
            rd_b_reg <= valid_reg[raddr_b] ? regs[raddr_b] : 32'd0;
        end
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

// File: rtl/mss_slot_map.sv
// ============================================================================
// mss_slot_map
// Word index modulo MEM_WORDS by reciprocal multiply. The quotient is
// registered when en is high; the remainder is formed from it next cycle.
// x must hold steady from en until slot is used.
// ============================================================================
module mss_slot_map #(
    parameter int MEM_WORDS = mss_pkg::MEM_WORDS_DEF
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [mss_pkg::WORD_IDX_W-1:0]    x,
    output logic [$clog2(MEM_WORDS)-1:0]      slot
);
    import mss_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);
    localparam int XW = WORD_IDX_W;
    localparam int SH = XW + AW;
    localparam int RW = XW + 1;
    localparam int PW = XW + RW;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << SH) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);
    localparam logic [RW-1:0] RECIP = RW'(RECIP64);
    localparam logic [XW-1:0] DIVISOR = XW'(MEM_WORDS);

    logic [PW-1:0] prod;
    logic [XW-1:0] q_reg;
    logic [XW-1:0] rem;

    // floor(x / MEM_WORDS), exact for every x below 2^XW
    assign prod = PW'(x) * PW'(RECIP);

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= XW'(prod >> SH);
        end
    end

    assign rem  = x - XW'(q_reg * DIVISOR);
    assign slot = AW'(rem);

endmodule

// File: rtl/mss_alu.sv
// ============================================================================
// mss_alu
// Decode and execute one instruction: register result, effective address,
// branch target and next PC.
// ============================================================================
module mss_alu (
    input  logic [31:0]    inst,
    input  logic [31:0]    pc,
    input  logic [31:0]    a,
    input  logic [31:0]    b,
    output mss_pkg::exec_t ex
);
    import mss_pkg::*;

    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [31:0] imm;
    logic [31:0] pc4;
    logic [31:0] sum_ai;
    logic        wr_en;
    logic [4:0]  wr_idx;
    logic [31:0] wr_val;

    assign op     = inst[31:26];
    assign rt     = inst[20:16];
    assign rd     = inst[15:11];
    assign fn     = inst[5:0];
    assign imm    = {{16{inst[15]}}, inst[15:0]};
    assign pc4    = pc + 32'd4;
    assign sum_ai = a + imm;

    always_comb begin
        ex            = '0;
        ex.kind       = K_UNKNOWN;
        ex.ea         = sum_ai;
        ex.store_data = b;
        ex.npc        = pc4;
        wr_en         = 1'b0;
        wr_idx        = rd;
        wr_val        = 32'd0;
        unique case (op)
            OP_RTYPE: begin
                unique case (fn)
                    FN_ADD: begin
                        ex.kind = K_ADD;
                        wr_en   = 1'b1;
                        wr_val  = a + b;
                    end
                    FN_SUB: begin
                        ex.kind = K_SUB;
                        wr_en   = 1'b1;
                        wr_val  = a - b;
                    end
                    default: ex.kind = K_RNOP;
                endcase
            end
            OP_ADDI: begin
                ex.kind = K_ADDI;
                wr_en   = 1'b1;
                wr_idx  = rt;
                wr_val  = sum_ai;
            end
            OP_LW: begin
                ex.kind   = K_LW;
                ex.is_mem = 1'b1;
                wr_en     = 1'b1;
                wr_idx    = rt;
            end
            OP_SW: begin
                ex.kind   = K_SW;
                ex.is_mem = 1'b1;
            end
            OP_BEQ: begin
                if (a == b) begin
                    ex.kind = K_BEQ_T;
                    ex.npc  = pc4 + {imm[29:0], 2'b00};
                end else begin
                    ex.kind = K_BEQ_N;
                end
            end
            default: ex.kind = K_UNKNOWN;
        endcase
        // drop writes to R0
        if (wr_en && (wr_idx != 5'd0)) begin
            ex.wr.en   = 1'b1;
            ex.wr.idx  = wr_idx;
            ex.wr.data = wr_val;
        end
    end

endmodule

// File: rtl/mips_subset_instruction_step.sv
// ============================================================================
// mips_subset_instruction_step
// Step engine for a MIPS32 subset (ADD, SUB, ADDI, LW, SW, BEQ) with a PC,
// a 32-entry register file and one unified instruction/data memory.
// ============================================================================
//
//  channel   ports                       direction  transaction
//  --------  --------------------------  ---------  ---------------------------
//  input     s_valid s_ready s_item      in         memory load or one step
//  result    m_valid m_ready m_item      out        one report per input item
//
//  Stepping: fetch read, register read, execute; a step at or past the end of
//  memory only reports a halt. LW and SW then add map and access, LW a
//  write-back; a memory load item runs map and access. The address passes a
//  modulo map before the memory port. Items share that port one at a time.
//  Reset: aresetn clears the PC, the register valid bits and the handshakes;
//  memory contents stay undefined until written.
//  Stalls: a one-deep input buffer takes the next transaction while the
//  current one executes; a held result blocks only the final cycle of the
//  next item.
//
module mips_subset_instruction_step #(
    parameter int MEM_WORDS = mss_pkg::MEM_WORDS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mss_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output mss_pkg::out_item_t m_item
);
    import mss_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);
    localparam int XW = WORD_IDX_W;
    localparam logic [31:0] PC_LIMIT = 32'(4 * MEM_WORDS);

    // input buffer
    in_item_t    pend_reg;
    logic        pend_valid_reg;
    logic        pend_take;

    // sequencer
    state_t      state_reg;
    state_t      state_next;
    logic [31:0] pc_reg;
    logic [31:0] pc_next;
    logic [31:0] inst_reg;
    logic        inst_load;
    exec_t       ex_reg;
    exec_t       ex_next;
    logic        ex_load;
    logic [XW-1:0] x_reg;
    logic [XW-1:0] x_next;
    logic        x_load;

    // output register
    out_item_t   out_reg;
    out_item_t   out_next;
    logic        out_valid_reg;
    logic        out_load;
    logic        out_free;

    // memory and register file ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;
    rf_wr_t        rf_wr;
    logic          rf_re;
    logic [31:0]   rf_a;
    logic [31:0]   rf_b;
    logic          map_en;
    logic [AW-1:0] slot;
    exec_t         ex_out;
    logic          halt;

    // ------------------------------------------------------------------
    // Datapath parts
    // ------------------------------------------------------------------
    mss_umem #(.MEM_WORDS(MEM_WORDS)) u_umem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // register addresses come straight off the fetched word
    mss_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (rf_wr),
        .re      (rf_re),
        .raddr_a (mem_rdata[25:21]),
        .raddr_b (mem_rdata[20:16]),
        .rdata_a (rf_a),
        .rdata_b (rf_b)
    );

    mss_slot_map #(.MEM_WORDS(MEM_WORDS)) u_slot_map (
        .aclk (aclk),
        .en   (map_en),
        .x    (x_reg),
        .slot (slot)
    );

    mss_alu u_alu (
        .inst (inst_reg),
        .pc   (pc_reg),
        .a    (rf_a),
        .b    (rf_b),
        .ex   (ex_out)
    );

    assign halt     = (pc_reg >= PC_LIMIT);
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !pend_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_item   = out_reg;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (pend_valid_reg) begin
                    if (!pend_reg.req_type) begin
                        state_next = S_MAP;
                    end else if (!halt) begin
                        state_next = S_DECODE;
                    end
                end
            end
            S_DECODE: state_next = S_EXEC;
            S_EXEC: begin
                if (ex_out.is_mem) begin
                    state_next = S_MAP;
                end else if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_MAP: state_next = S_ACCESS;
            S_ACCESS: begin
                if (ex_reg.kind == K_LW) begin
                    state_next = S_LOAD_WB;
                end else if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_LOAD_WB: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs
    // ------------------------------------------------------------------
    always_comb begin
        pend_take = 1'b0;
        pc_next   = pc_reg;
        inst_load = 1'b0;
        ex_load   = 1'b0;
        ex_next   = ex_out;
        x_load    = 1'b0;
        x_next    = x_reg;
        out_load  = 1'b0;
        out_next  = '0;
        mem_we    = 1'b0;
        mem_waddr = slot;
        mem_wdata = ex_reg.store_data;
        mem_re    = 1'b0;
        mem_raddr = slot;
        rf_wr     = '0;
        rf_re     = 1'b0;
        map_en    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (pend_valid_reg) begin
                    if (!pend_reg.req_type) begin
                        // memory load: hold data, map the word index
                        pend_take          = 1'b1;
                        ex_load            = 1'b1;
                        ex_next            = '0;
                        ex_next.kind       = K_LOAD;
                        ex_next.store_data = pend_reg.load_data;
                        ex_next.npc        = pc_reg;
                        x_load             = 1'b1;
                        x_next             = XW'(pend_reg.load_addr);
                    end else if (halt) begin
                        // report halt without touching state
                        if (out_free) begin
                            pend_take        = 1'b1;
                            out_load         = 1'b1;
                            out_next.kind    = K_HALT;
                            out_next.exec_pc = pc_reg;
                            out_next.next_pc = pc_reg;
                        end
                    end else begin
                        // fetch: PC is in range, so no wrap is needed
                        pend_take = 1'b1;
                        mem_re    = 1'b1;
                        mem_raddr = pc_reg[AW+1:2];
                    end
                end
            end
            S_DECODE: begin
                inst_load = 1'b1;
                rf_re     = 1'b1;
            end
            S_EXEC: begin
                if (ex_out.is_mem) begin
                    ex_load = 1'b1;
                    x_load  = 1'b1;
                    x_next  = ex_out.ea[31:2];
                end else if (out_free) begin
                    rf_wr                = ex_out.wr;
                    pc_next              = ex_out.npc;
                    out_load             = 1'b1;
                    out_next.kind        = ex_out.kind;
                    out_next.exec_pc     = pc_reg;
                    out_next.instr_word  = inst_reg;
                    out_next.reg_written = ex_out.wr.en;
                    out_next.reg_index   = ex_out.wr.idx;
                    out_next.reg_value   = ex_out.wr.data;
                    out_next.next_pc     = ex_out.npc;
                end
            end
            S_MAP: begin
                map_en = 1'b1;
            end
            S_ACCESS: begin
                if (ex_reg.kind == K_LW) begin
                    mem_re = 1'b1;
                end else if (out_free) begin
                    mem_we   = 1'b1;
                    out_load = 1'b1;
                    if (ex_reg.kind == K_LOAD) begin
                        out_next.kind    = K_LOAD;
                        out_next.next_pc = pc_reg;
                    end else begin
                        pc_next                = ex_reg.npc;
                        out_next.kind          = K_SW;
                        out_next.exec_pc       = pc_reg;
                        out_next.instr_word    = inst_reg;
                        out_next.mem_written   = 1'b1;
                        out_next.mem_byte_addr = ex_reg.ea;
                        out_next.mem_value     = ex_reg.store_data;
                        out_next.next_pc       = ex_reg.npc;
                    end
                end
            end
            S_LOAD_WB: begin
                if (out_free) begin
                    rf_wr.en               = ex_reg.wr.en;
                    rf_wr.idx              = ex_reg.wr.idx;
                    rf_wr.data             = mem_rdata;
                    pc_next                = ex_reg.npc;
                    out_load               = 1'b1;
                    out_next.kind          = K_LW;
                    out_next.exec_pc       = pc_reg;
                    out_next.instr_word    = inst_reg;
                    out_next.reg_written   = ex_reg.wr.en;
                    out_next.reg_index     = ex_reg.wr.idx;
                    out_next.reg_value     = ex_reg.wr.en ? mem_rdata : 32'd0;
                    out_next.mem_byte_addr = ex_reg.ea;
                    out_next.mem_value     = mem_rdata;
                    out_next.next_pc       = ex_reg.npc;
                end
            end
            default: begin
                pend_take = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pc_reg         <= 32'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            // advance the input buffer
            if (s_valid && s_ready) begin
                pend_valid_reg <= 1'b1;
            end else if (pend_take) begin
                pend_valid_reg <= 1'b0;
            end
            // hold the result until taken
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pend_reg <= s_item;
        end
        if (inst_load) begin
            inst_reg <= mem_rdata;
        end
        if (ex_load) begin
            ex_reg <= ex_next;
        end
        if (x_load) begin
            x_reg <= x_next;
        end
        if (out_load) begin
            out_reg <= out_next;
        end
    end

endmodule

// File: test/mips_subset_instruction_step_test.sv
`timescale 1ns / 1ps
// ============================================================================
// mips_subset_instruction_step_test
// Self-checking bench for the MIPS subset step engine: places programs with
// memory-load transactions, single-steps them and checks every report against
// a cycle-free model of PC, register file and unified memory.
// ============================================================================
module mips_subset_instruction_step_test;
    import mss_pkg::*;

    localparam int unsigned MEM_WORDS = MEM_WORDS_DEF;
    // First byte address past the end of memory: a step from here halts
    localparam logic [31:0] PC_LIMIT  = 4 * MEM_WORDS;
    // Opcode that the engine does not implement
    localparam logic [5:0]  OP_SPARE  = 6'h3F;
    // Cycles to wait after the last report; LW is the longest item
    localparam int          TAIL_CYCLES = 24;
    // Length of the long receiver hold-off
    localparam int          LONG_HOLD_CYCLES = 200;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_item;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_item;

    mips_subset_instruction_step u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Architectural state as the engine should hold it after every accepted
    // transaction. mem_set marks words that have been written; the stimulus
    // never fetches or loads a word whose bit is still clear.
    // ------------------------------------------------------------------------
    logic [31:0] pc_q;
    logic [31:0] gpr     [32];
    logic [31:0] mem_img [MEM_WORDS];
    bit          mem_set [MEM_WORDS];

    out_item_t   report_q [$];   // expected reports, oldest first
    out_item_t   want_r;
    int          n_fail = 0;
    int          n_sent = 0;
    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;
    int          hold_req_cnt = 0;  // bumped by a test to ask for a long hold-off
    int          hold_ack_cnt = 0;  // requests the receiver has started
    int          sink_hold = 0;     // cycles the receiver still holds off

    function automatic int unsigned word_of(input logic [31:0] byte_addr);
        return (byte_addr >> 2) % MEM_WORDS;
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Apply one transaction to the state and return the report it causes
    function automatic out_item_t predict_report(input in_item_t it);
        out_item_t   r;
        logic [31:0] inst, a, b, imm, npc, ea;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, wi;
        logic        wr;
        logic [31:0] wv;
        int unsigned slot;

        r = '0;
        if (!it.req_type) begin
            slot = it.load_addr % MEM_WORDS;
            mem_img[slot] = it.load_data;
            mem_set[slot] = 1'b1;
            r.kind    = K_LOAD;
            r.next_pc = pc_q;
            return r;
        end
        if (pc_q >= PC_LIMIT) begin
            r.kind    = K_HALT;
            r.exec_pc = pc_q;
            r.next_pc = pc_q;
            return r;
        end

        inst = mem_img[word_of(pc_q)];
        op   = inst[31:26];
        rs   = inst[25:21];
        rt   = inst[20:16];
        rd   = inst[15:11];
        fn   = inst[5:0];
        imm  = sext16(inst[15:0]);
        a    = gpr[rs];
        b    = gpr[rt];
        npc  = pc_q + 32'd4;
        wr   = 1'b0;
        wi   = '0;
        wv   = '0;
        r.exec_pc    = pc_q;
        r.instr_word = inst;

        case (op)
            OP_RTYPE: begin
                if (fn == FN_ADD) begin
                    r.kind = K_ADD;
                    wr = 1'b1; wi = rd; wv = a + b;
                end else if (fn == FN_SUB) begin
                    r.kind = K_SUB;
                    wr = 1'b1; wi = rd; wv = a - b;
                end else begin
                    r.kind = K_RNOP;
                end
            end
            OP_ADDI: begin
                r.kind = K_ADDI;
                wr = 1'b1; wi = rt; wv = a + imm;
            end
            OP_LW: begin
                ea = a + imm;
                r.kind          = K_LW;
                r.mem_byte_addr = ea;
                r.mem_value     = mem_img[word_of(ea)];
                wr = 1'b1; wi = rt; wv = mem_img[word_of(ea)];
            end
            OP_SW: begin
                ea = a + imm;
                mem_img[word_of(ea)] = b;
                mem_set[word_of(ea)] = 1'b1;
                r.kind          = K_SW;
                r.mem_written   = 1'b1;
                r.mem_byte_addr = ea;
                r.mem_value     = b;
            end
            OP_BEQ: begin
                if (a == b) begin
                    r.kind = K_BEQ_T;
                    npc = npc + (imm << 2);
                end else begin
                    r.kind = K_BEQ_N;
                end
            end
            default: r.kind = K_UNKNOWN;
        endcase

        // Writes to R0 are dropped and leave the register fields at zero
        if (wr && wi != 5'd0) begin
            gpr[wi]       = wv;
            r.reg_written = 1'b1;
            r.reg_index   = wi;
            r.reg_value   = wv;
        end
        pc_q      = npc;
        r.next_pc = npc;
        return r;
    endfunction

    // PC after executing inst at the current PC, from the current registers
    function automatic logic [31:0] peek_next_pc(input logic [31:0] inst);
        if (inst[31:26] == OP_BEQ && gpr[inst[25:21]] == gpr[inst[20:16]])
            return pc_q + 32'd4 + (sext16(inst[15:0]) << 2);
        return pc_q + 32'd4;
    endfunction

    function automatic logic [31:0] r_word(input logic [4:0] rs, input logic [4:0] rt,
                                           input logic [4:0] rd, input logic [5:0] fn);
        return {OP_RTYPE, rs, rt, rd, 5'($urandom), fn};
    endfunction

    function automatic logic [31:0] i_word(input logic [5:0] op, input logic [4:0] rs,
                                           input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // Favor a few low registers so that results feed later instructions
    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(0, 7));
    endfunction

    function automatic logic [31:0] random_instr();
        logic [4:0]  rs, rt, rd;
        logic [15:0] imm;
        logic [5:0]  op, fn;
        int          sel;

        rs  = pick_reg();
        rt  = pick_reg();
        rd  = pick_reg();
        imm = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                          : 16'($urandom_range(0, 127)) - 16'd64;
        sel = $urandom_range(0, 99);
        if (sel < 14) return r_word(rs, rt, rd, FN_ADD);
        if (sel < 26) return r_word(rs, rt, rd, FN_SUB);
        if (sel < 31) begin
            fn = 6'($urandom);
            if (fn == FN_ADD || fn == FN_SUB) fn = fn ^ 6'h01;
            return r_word(rs, rt, rd, fn);
        end
        if (sel < 50) return i_word(OP_ADDI, rs, rt, imm);
        if (sel < 64) return i_word(OP_LW, rs, rt, imm);
        if (sel < 78) return i_word(OP_SW, rs, rt, imm);
        if (sel < 93) begin
            // Equal operands often, and short hops so loops stay inside memory
            if ($urandom_range(0, 99) < 40) rt = rs;
            if ($urandom_range(0, 4) != 0) imm = 16'($urandom_range(0, 12)) - 16'd6;
            return i_word(OP_BEQ, rs, rt, imm);
        end
        if (sel < 97) begin
            op = 6'($urandom);
            if (op inside {OP_RTYPE, OP_ADDI, OP_LW, OP_SW, OP_BEQ}) op = OP_SPARE;
            return i_word(op, rs, rt, imm);
        end
        return $urandom;
    endfunction

    function automatic in_item_t load_item(input int unsigned slot, input logic [31:0] data);
        in_item_t it;
        it.req_type  = 1'b0;
        it.load_addr = 10'(slot);
        it.load_data = data;
        return it;
    endfunction

    // Step transaction; the load fields are don't-care, so keep them moving
    function automatic in_item_t step_item();
        in_item_t it;
        it.req_type  = 1'b1;
        it.load_addr = 10'($urandom);
        it.load_data = $urandom;
        return it;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
            n_fail++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender: idle each cycle with the set odds, then hold valid and payload
    // until accepted. Valid is only lowered ahead of a gap, never at the
    // acceptance edge, so back-to-back transactions keep it high.
    // ------------------------------------------------------------------------
    task automatic send_item(input in_item_t it);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        report_q.push_back(predict_report(it));
        n_sent++;
    endtask

    // Drop valid and hold off until every pending report has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (report_q.size() != 0) @(posedge aclk);
    endtask

    // Place inst at the current PC and execute it
    task automatic run_instr(input logic [31:0] inst);
        send_item(load_item(word_of(pc_q), inst));
        send_item(step_item());
    endtask

    // One random step, preceded by the loads that keep it legal: code at the
    // PC, a written word behind any LW, and no path past the end of memory.
    task automatic random_step();
        int unsigned slot;
        int          off;
        logic [31:0] inst, ea;

        slot = word_of(pc_q);
        if (!mem_set[slot] || $urandom_range(0, 99) < 15)
            send_item(load_item(slot, random_instr()));
        inst = mem_img[slot];
        if (peek_next_pc(inst) >= PC_LIMIT) begin
            // Redirect with an always-taken branch to a random word
            off = int'($urandom_range(0, MEM_WORDS - 1)) - int'(pc_q >> 2) - 1;
            send_item(load_item(slot, i_word(OP_BEQ, 5'd0, 5'd0, 16'(off))));
            inst = mem_img[slot];
        end
        if (inst[31:26] == OP_LW) begin
            ea = gpr[inst[25:21]] + sext16(inst[15:0]);
            if (!mem_set[word_of(ea)]) send_item(load_item(word_of(ea), $urandom));
        end
        send_item(step_item());
    endtask

    // ------------------------------------------------------------------------
    // Receiver: check each report against the oldest expectation and choose
    // the next cycle's ready. A long hold-off counts down here.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (report_q.size() == 0) begin
                $error("report with no transaction pending: kind %0d", m_item.kind);
                n_fail++;
            end else begin
                want_r = report_q.pop_front();
                check_field("kind",          32'(want_r.kind),        32'(m_item.kind));
                check_field("exec_pc",       want_r.exec_pc,          m_item.exec_pc);
                check_field("instr_word",    want_r.instr_word,       m_item.instr_word);
                check_field("reg_written",   32'(want_r.reg_written), 32'(m_item.reg_written));
                check_field("reg_index",     32'(want_r.reg_index),   32'(m_item.reg_index));
                check_field("reg_value",     want_r.reg_value,        m_item.reg_value);
                check_field("mem_written",   32'(want_r.mem_written), 32'(m_item.mem_written));
                check_field("mem_byte_addr", want_r.mem_byte_addr,    m_item.mem_byte_addr);
                check_field("mem_value",     want_r.mem_value,        m_item.mem_value);
                check_field("next_pc",       want_r.next_pc,          m_item.next_pc);
            end
        end
        if (hold_ack_cnt != hold_req_cnt) begin
            hold_ack_cnt <= hold_req_cnt;
            sink_hold    <= LONG_HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else if (sink_hold > 0) begin
            m_ready   <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // ADD, SUB, ADDI with immediate extremes and a write aimed at R0
    task automatic test_arith();
        run_instr(i_word(OP_ADDI, 5'd0, 5'd1, 16'hFFFF));
        run_instr(i_word(OP_ADDI, 5'd0, 5'd2, 16'h7FFF));
        run_instr(r_word(5'd1, 5'd2, 5'd3, FN_ADD));
        run_instr(r_word(5'd2, 5'd1, 5'd4, FN_SUB));
        run_instr(i_word(OP_ADDI, 5'd1, 5'd31, 16'h8000));
        run_instr(r_word(5'd1, 5'd2, 5'd0, FN_ADD));
    endtask

    // Unsupported functs and opcodes only advance the PC
    task automatic test_other_ops();
        run_instr(r_word(5'd3, 5'd4, 5'd5, ~FN_ADD));
        run_instr(32'hFFFF_FFFF);
        run_instr(32'h0000_0000);
    endtask

    // Store, then loads with ignored low bits, a wrapped address and R0 target
    task automatic test_memory();
        run_instr(i_word(OP_SW, 5'd0, 5'd31, 16'h0200));
        run_instr(i_word(OP_LW, 5'd0, 5'd5, 16'h0203));
        send_item(load_item(MEM_WORDS - 1, 32'hA5A5_5A5A));
        run_instr(i_word(OP_LW, 5'd0, 5'd6, 16'hFFFC));
        run_instr(i_word(OP_LW, 5'd0, 5'd0, 16'h0201));
    endtask

    task automatic test_branch();
        run_instr(i_word(OP_BEQ, 5'd1, 5'd1, 16'h0001));
        run_instr(i_word(OP_BEQ, 5'd1, 5'd2, 16'h0005));
    endtask

    // Stall the receiver for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        drain();
        hold_req_cnt++;
        repeat (30) random_step();
        drain();
    endtask

    task automatic test_random(input int n_items, input int src_pct, input int sink_pct);
        int stop_at;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        stop_at = n_sent + n_items;
        while (n_sent < stop_at) begin
            if ($urandom_range(0, 99) < 8)
                send_item(load_item($urandom_range(0, MEM_WORDS - 1), $urandom));
            else
                random_step();
        end
        drain();
    endtask

    // Branch to exactly the end of memory; from then on every step halts.
    // Halting is permanent, so this runs last.
    task automatic test_halt();
        run_instr(i_word(OP_BEQ, 5'd0, 5'd0, 16'((PC_LIMIT - pc_q - 32'd4) >> 2)));
        send_item(step_item());
        send_item(load_item(MEM_WORDS - 1, 32'hFFFF_FFFF));
        send_item(step_item());
        drain();
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_item  <= '0;
        pc_q = '0;
        foreach (gpr[i]) gpr[i] = '0;
        foreach (mem_img[i]) begin
            mem_img[i] = '0;
            mem_set[i] = 1'b0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct  = 10;
        sink_idle_pct = 10;
        test_arith();
        test_other_ops();
        test_memory();
        test_branch();
        test_backpressure();
        test_random(400, 26, 63);
        test_random(400, 63, 26);
        test_random(400, 0, 0);
        test_halt();

        // Let any stray report surface before the verdict
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (n_fail == 0 && report_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
